[hw/rtl/gccc_pkg.sv]
// ----------------------------------------------------------------------------
// gccc_pkg
// Shared widths, types and sequencer states for the gain constraint clamp
// and cost unit.
// ----------------------------------------------------------------------------
package gccc_pkg;

  localparam int VALUE_WIDTH           = 32;
  localparam int FRACTION_BITS_DEFAULT = 16;
  localparam int COST_WIDTH            = 48;
  localparam int DT_WIDTH              = 31;
  localparam logic [DT_WIDTH-1:0] DT_RESET = DT_WIDTH'(655);

  localparam int Y_WIDTH   = VALUE_WIDTH + 2;
  localparam int D_WIDTH   = Y_WIDTH + 2;
  localparam int NUM_WIDTH = 3 * VALUE_WIDTH;
  localparam int QUO_WIDTH = COST_WIDTH - 1;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_KV    = 16'h0002,
    S_KVSAT = 16'h0004,
    S_Y     = 16'h0008,
    S_CLAMP = 16'h0010,
    S_IMP   = 16'h0020,
    S_HESS  = 16'h0040,
    S_TERM  = 16'h0080,
    S_SQ    = 16'h0100,
    S_PL    = 16'h0200,
    S_PH    = 16'h0400,
    S_PA    = 16'h0800,
    S_DIV   = 16'h1000,
    S_DIVW  = 16'h2000,
    S_SAT   = 16'h4000,
    S_ACC   = 16'h8000
  } state_t;

endpackage

[hw/rtl/gain_constraint_clamp_cost_top.sv]
// ----------------------------------------------------------------------------
// gain_constraint_clamp_cost_top
// Clamps y = bias - gain*velocity to the effort limit, forms impulse, Hessian
// diagonal and cost term, and keeps a saturating running cost total.
//
// Channel  Handshake               Payload
// in       in_valid / in_stall     gain, bias, effort_limit, velocity, last
// out      out_valid / out_stall   impulse, hessian_diag, total_cost, last_res
// cfg      cfg_wr_en               cfg_wr_data (time step)
//
// A positive gain adds a division by the 47-step radix-2 divider; a
// non-positive gain saturates the cost term directly instead.
// All products go through one shared 32x32 multiplier, one per cycle.
// in_stall is high in reset and from accept until the result is loaded into
// the output register; a stalled output holds the next item in its final step.
// Reset is synchronous: time step returns to 655, cost total to zero.
// ----------------------------------------------------------------------------
module gain_constraint_clamp_cost_top import gccc_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [DT_WIDTH-1:0]    cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] gain,
  input  logic [VALUE_WIDTH-1:0] bias,
  input  logic [VALUE_WIDTH-2:0] effort_limit,
  input  logic [VALUE_WIDTH-1:0] velocity,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] impulse,
  output logic [VALUE_WIDTH-1:0] hessian_diag,
  output logic [COST_WIDTH-1:0]  total_cost,
  output logic                   last_res
);

  localparam int PW = 2 * VALUE_WIDTH;
  localparam int VM = VALUE_WIDTH - 1;
  localparam int CM = COST_WIDTH - 1;

  function automatic logic [VALUE_WIDTH-1:0] mag_v(input logic [VALUE_WIDTH-1:0] x);
    return x[VM] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [63:0] sat_mag(input logic [NUM_WIDTH-1:0] m, input logic neg,
                                          input int unsigned w);
    logic [NUM_WIDTH-1:0] lim;
    logic [63:0]          r;
    lim = NUM_WIDTH'(1) << (w - 1);
    if (neg) begin
      r = (m > lim) ? (64'd0 - lim[63:0]) : (64'd0 - m[63:0]);
    end else begin
      r = (m > lim - 1'b1) ? (lim[63:0] - 64'd1) : m[63:0];
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [DT_WIDTH-1:0]    dt;
  logic [COST_WIDTH-1:0]  acc;
  logic [VALUE_WIDTH-1:0] k, b, v;
  logic [VALUE_WIDTH-2:0] e;
  logic                   last_r;

  logic signed [Y_WIDTH-1:0]     kv, y;
  logic signed [VALUE_WIDTH-1:0] bound;
  logic                          in_limits;
  logic                          d_neg;
  logic [D_WIDTH-2:0]            d_mag;
  logic [VALUE_WIDTH-1:0]        imp, hess;
  logic [VALUE_WIDTH-1:0]        ma;
  logic [PW-1:0]                 mb;
  logic [PW-1:0]                 prod;
  logic [NUM_WIDTH-1:0]          num;
  logic [COST_WIDTH-1:0]         term;

  logic [VALUE_WIDTH-1:0] mul_a, mul_b;
  logic [PW-1:0]          mul_p;
  logic                   kpos;
  logic                   out_free;
  logic                   div_start;
  logic [NUM_WIDTH-1:0]   div_num;
  logic [VALUE_WIDTH-1:0] div_den;
  div_stat_t              div_stat;
  logic [QUO_WIDTH-1:0]   div_quo;
  logic                   div_neg;

  logic [Y_WIDTH:0]              y_diff;
  logic signed [Y_WIDTH-1:0]     e_hi, e_lo;
  logic [D_WIDTH-1:0]            d_full;
  logic [VALUE_WIDTH-1:0]        y_mag;
  logic [COST_WIDTH:0]           sum;
  logic [COST_WIDTH-1:0]         total_next;

  assign kpos     = !k[VM] && (k != '0);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = rst || (state != S_IDLE);

  assign y_diff = {{(Y_WIDTH + 1 - VALUE_WIDTH){b[VM]}}, b} - {kv[Y_WIDTH-1], kv};
  assign e_hi   = signed'(Y_WIDTH'(e));
  assign e_lo   = -e_hi;
  assign d_full = {y[Y_WIDTH-1], y, 1'b0}
                - {{(D_WIDTH - VALUE_WIDTH){bound[VM]}}, bound};
  assign y_mag  = y[Y_WIDTH-1] ? VALUE_WIDTH'(~y + 1'b1) : VALUE_WIDTH'(y);
  assign sum    = {acc[CM], acc} + {term[CM], term};
  assign total_next = (sum[COST_WIDTH] != sum[CM])
                    ? (sum[COST_WIDTH] ? {1'b1, {CM{1'b0}}} : {1'b0, {CM{1'b1}}})
                    : sum[CM:0];

  // shared multiplier
  always_comb begin
    case (state)
      S_KV: begin
        mul_a = mag_v(k);
        mul_b = mag_v(v);
      end
      S_IMP: begin
        mul_a = VALUE_WIDTH'(dt);
        mul_b = mag_v(bound);
      end
      S_HESS: begin
        mul_a = VALUE_WIDTH'(dt);
        mul_b = mag_v(k);
      end
      S_TERM: begin
        mul_a = y_mag;
        mul_b = y_mag;
      end
      S_PL: begin
        mul_a = ma;
        mul_b = mb[VALUE_WIDTH-1:0];
      end
      S_PH: begin
        mul_a = ma;
        mul_b = mb[PW-1:VALUE_WIDTH];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign div_start = (state == S_DIV);
  assign div_num   = in_limits ? (num >> FRACTION_BITS) : num;
  assign div_den   = {k[VALUE_WIDTH-2:0], 1'b0};
  assign div_neg   = !in_limits && (imp[VM] != d_neg);

  gccc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_KV;
      S_KV:    state_next = S_KVSAT;
      S_KVSAT: state_next = S_Y;
      S_Y:     state_next = S_CLAMP;
      S_CLAMP: state_next = S_IMP;
      S_IMP:   state_next = S_HESS;
      S_HESS:  state_next = S_TERM;
      S_TERM:  state_next = (kpos && in_limits) ? S_SQ : S_PL;
      S_SQ:    state_next = S_PL;
      S_PL:    state_next = S_PH;
      S_PH:    state_next = S_PA;
      S_PA:    state_next = kpos ? S_DIV : S_SAT;
      S_DIV:   state_next = S_DIVW;
      S_DIVW:  if (div_stat.done) state_next = S_ACC;
      S_SAT:   state_next = S_ACC;
      S_ACC:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dt        <= DT_RESET;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        dt <= cfg_wr_data;
      end
      if (state == S_ACC && out_free) begin
        out_valid <= 1'b1;
        acc       <= last_r ? '0 : total_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        k      <= gain;
        b      <= bias;
        e      <= effort_limit;
        v      <= velocity;
        last_r <= last;
      end
      S_KV: begin
        prod <= mul_p;
      end
      S_KVSAT: begin
        kv <= Y_WIDTH'(sat_mag(NUM_WIDTH'(prod >> FRACTION_BITS), k[VM] ^ v[VM], Y_WIDTH));
      end
      S_Y: begin
        if (y_diff[Y_WIDTH] != y_diff[Y_WIDTH-1]) begin
          y <= y_diff[Y_WIDTH] ? {1'b1, {(Y_WIDTH-1){1'b0}}} : {1'b0, {(Y_WIDTH-1){1'b1}}};
        end else begin
          y <= y_diff[Y_WIDTH-1:0];
        end
      end
      S_CLAMP: begin
        if (y > e_hi) begin
          bound     <= VALUE_WIDTH'(e_hi);
          in_limits <= 1'b0;
        end else if (y < e_lo) begin
          bound     <= VALUE_WIDTH'(e_lo);
          in_limits <= 1'b0;
        end else begin
          bound     <= VALUE_WIDTH'(y);
          in_limits <= 1'b1;
        end
      end
      S_IMP: begin
        prod  <= mul_p;
        d_neg <= d_full[D_WIDTH-1];
        d_mag <= d_full[D_WIDTH-1] ? (D_WIDTH-1)'(~d_full + 1'b1) : d_full[D_WIDTH-2:0];
      end
      S_HESS: begin
        imp  <= VALUE_WIDTH'(sat_mag(NUM_WIDTH'(prod >> FRACTION_BITS), bound[VM],
                                     VALUE_WIDTH));
        prod <= mul_p;
      end
      S_TERM: begin
        hess <= in_limits ? VALUE_WIDTH'(sat_mag(NUM_WIDTH'(prod >> FRACTION_BITS), k[VM],
                                                 VALUE_WIDTH)) : '0;
        prod <= mul_p;
        if (kpos && in_limits) begin
          ma <= VALUE_WIDTH'(dt);
        end else if (kpos) begin
          ma <= mag_v(imp);
          mb <= PW'(d_mag);
        end else begin
          ma <= mag_v(imp);
          mb <= PW'(mag_v(v));
        end
      end
      S_SQ: begin
        mb <= prod;
      end
      S_PL: begin
        prod <= mul_p;
      end
      S_PH: begin
        num  <= NUM_WIDTH'(prod);
        prod <= mul_p;
      end
      S_PA: begin
        num <= num + (NUM_WIDTH'(prod) << VALUE_WIDTH);
      end
      S_DIVW: begin
        if (div_stat.done) begin
          if (div_stat.ovf) begin
            term <= div_neg ? {1'b1, {CM{1'b0}}} : {1'b0, {CM{1'b1}}};
          end else begin
            term <= div_neg ? (~{1'b0, div_quo} + 1'b1) : {1'b0, div_quo};
          end
        end
      end
      S_SAT: begin
        term <= COST_WIDTH'(sat_mag(num >> FRACTION_BITS, imp[VM] == v[VM], COST_WIDTH));
      end
      S_ACC: begin
        if (out_free) begin
          impulse      <= imp;
          hessian_diag <= hess;
          total_cost   <= total_next;
          last_res     <= last_r;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_out_from_acc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_ACC)
    else $error("output beat raised outside the accumulate step");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIVW)
    else $error("divider finished while sequencer not waiting");

  a_acc_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && out_free && last_r) |=> acc == '0)
    else $error("cost total not cleared after last beat");
`endif

endmodule

[hw/rtl/gccc_div.sv]
// ----------------------------------------------------------------------------
// gccc_div
// Restoring radix-2 divider, one quotient bit per cycle, with an up-front
// overflow check against the quotient width.
// ----------------------------------------------------------------------------
module gccc_div import gccc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUM_WIDTH-1:0]   num,
  input  logic [VALUE_WIDTH-1:0] den,
  output div_stat_t              stat,
  output logic [QUO_WIDTH-1:0]   quo
);

  localparam int CNT_W = $clog2(QUO_WIDTH + 1);

  logic                   busy;
  logic                   ovf;
  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH-1:0] rem;
  logic [QUO_WIDTH-1:0]   qn;
  logic [VALUE_WIDTH:0]   trial;
  logic                   fits;
  logic                   too_big;

  assign too_big = num[NUM_WIDTH-1:QUO_WIDTH] >= (NUM_WIDTH - QUO_WIDTH)'(den);
  assign trial   = {rem, qn[QUO_WIDTH-1]};
  assign fits    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ovf  <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      ovf  <= too_big;
      cnt  <= too_big ? '0 : CNT_W'(QUO_WIDTH);
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[QUO_WIDTH +: VALUE_WIDTH];
      qn  <= num[QUO_WIDTH-1:0];
    end else if (busy && cnt != '0) begin
      rem <= fits ? VALUE_WIDTH'(trial - {1'b0, den}) : trial[VALUE_WIDTH-1:0];
      qn  <= {qn[QUO_WIDTH-2:0], fits};
    end
  end

  assign stat.done = busy && (cnt == '0);
  assign stat.ovf  = ovf;
  assign quo       = qn;

endmodule
